[hdl/sdeg_pkg.sv]
// shared constants, register codes and the structs passed between the front,
// the queue and the back of the second-difference gradient core; no dependencies
package sdeg_pkg;

    localparam int MAX_FRAMES_DEF  = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int SAMPLE_W    = 32;
    localparam int COEF_W      = 32;
    localparam int FCOUNT_W    = 13;
    localparam int GRAD_W      = 48;
    localparam int IDX_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int FCOUNT_MIN  = 4;

    // five stencil taps, four stored samples
    localparam int TAPS        = 5;
    localparam int WIN_DEPTH   = 4;

    // coef*coef is 64 bits, a sum of three of them needs 66
    localparam int PROD_W      = 2 * COEF_W;
    localparam int WEIGHT_W    = PROD_W + 2;
    localparam int SPLIT_W     = 33;
    localparam int WHI_W       = WEIGHT_W - SPLIT_W;
    localparam int PLO_W       = SPLIT_W + 1 + SAMPLE_W;
    localparam int PHI_W       = WHI_W + SAMPLE_W;
    // exact sum of five weighted taps fits in 99 bits
    localparam int ACC_W       = 100;
    // q48.48 down to q32.16
    localparam int ROUND_SHIFT = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A      = 2'd0,
        CFG_COEF_B      = 2'd1,
        CFG_COEF_C      = 2'd2,
        CFG_FRAME_COUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COEF_W-1:0] a;
        logic signed [COEF_W-1:0] b;
        logic signed [COEF_W-1:0] c;
    } t_coef;

    // one classified sample that yields one or three gradients
    typedef struct packed {
        logic [TAPS-1:0][SAMPLE_W-1:0] samples;   // [0] oldest .. [4] newest
        logic                          flush;
        logic                          ge3;
        logic                          ge4;
        logic [IDX_W-1:0]              idx;       // low bits of the sample index
    } t_qent;

    typedef struct packed {
        logic [IDX_W-1:0] frame_index;
        logic             row_last;
    } t_tag;

    // one gradient: taps [0] two frames back .. [4] two frames ahead
    typedef struct packed {
        logic [TAPS-1:0][SAMPLE_W-1:0] taps;
        logic                          has_c;
        logic                          has_b;
        logic                          has_a;
        t_tag                          tag;
    } t_job;

endpackage

[hdl/sdeg_front.sv]
// front end: takes sample requests, keeps the sample window and the frame
// counter, and classifies each sample into a queue entry; uses sdeg_pkg
module sdeg_front #(
    parameter int MAX_FRAMES = sdeg_pkg::MAX_FRAMES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    input  logic signed [sdeg_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [sdeg_pkg::FCOUNT_W-1:0]       i_frame_count,
    input  logic                                i_full,
    output logic                                o_stall,
    output logic                                o_push,
    output sdeg_pkg::t_qent                     o_entry
);

    localparam int CNT_W = $clog2(MAX_FRAMES);
    localparam int CMP_W = ((CNT_W > sdeg_pkg::FCOUNT_W) ? CNT_W : sdeg_pkg::FCOUNT_W) + 1;
    localparam int IW    = (CNT_W > sdeg_pkg::IDX_W) ? CNT_W : sdeg_pkg::IDX_W;

    logic [CNT_W-1:0]                r_cnt;
    logic [sdeg_pkg::SAMPLE_W-1:0]   r_win [sdeg_pkg::WIN_DEPTH];

    logic             accept;
    logic             row_end;
    logic [CMP_W-1:0] n_wide;
    logic [CMP_W-1:0] fc;
    logic [CMP_W-1:0] t_eff;
    logic [IW-1:0]    n_idx;

    always_comb begin
        n_wide = CMP_W'(r_cnt);
        fc     = CMP_W'(i_frame_count);
        if (fc < CMP_W'(sdeg_pkg::FCOUNT_MIN)) begin
            t_eff = CMP_W'(sdeg_pkg::FCOUNT_MIN);
        end else if (fc > CMP_W'(MAX_FRAMES)) begin
            t_eff = CMP_W'(MAX_FRAMES);
        end else begin
            t_eff = fc;
        end
        // a lowered frame count ends the row early
        row_end = (n_wide + CMP_W'(1)) >= t_eff;
        accept  = i_valid && !i_full;
        o_push  = accept && (row_end || (n_wide >= CMP_W'(2)));
        n_idx   = IW'(r_cnt);

        o_entry.samples[0] = r_win[3];
        o_entry.samples[1] = r_win[2];
        o_entry.samples[2] = r_win[1];
        o_entry.samples[3] = r_win[0];
        o_entry.samples[4] = i_sample_value;
        o_entry.flush      = row_end;
        o_entry.ge3        = n_wide >= CMP_W'(3);
        o_entry.ge4        = n_wide >= CMP_W'(4);
        o_entry.idx        = n_idx[sdeg_pkg::IDX_W-1:0];
    end

    assign o_stall = i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < sdeg_pkg::WIN_DEPTH; i++) begin
                r_win[i] <= '0;
            end
        end else if (accept) begin
            if (row_end) begin
                r_cnt <= '0;
                for (int i = 0; i < sdeg_pkg::WIN_DEPTH; i++) begin
                    r_win[i] <= '0;
                end
            end else begin
                r_cnt    <= r_cnt + CNT_W'(1);
                r_win[0] <= i_sample_value;
                for (int i = 1; i < sdeg_pkg::WIN_DEPTH; i++) begin
                    r_win[i] <= r_win[i-1];
                end
            end
        end
    end

endmodule

[hdl/sdeg_queue.sv]
// short first-in first-out queue of classified samples between front and
// back; uses sdeg_pkg for the entry type
module sdeg_queue #(
    parameter int DEPTH = sdeg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sdeg_pkg::t_qent i_entry,
    input  logic            i_pop,
    output sdeg_pkg::t_qent o_head,
    output logic            o_head_valid,
    output logic            o_full
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    sdeg_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]   r_wr;
    logic [PW-1:0]   r_rd;
    logic [CW-1:0]   r_count;

    logic do_push;
    logic do_pop;

    assign o_head       = r_mem[r_rd];
    assign o_head_valid = r_count != '0;
    assign o_full       = r_count == CW'(DEPTH);
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

[hdl/sdeg_back.sv]
// back end: expands queue entries into gradient jobs and runs the stencil
// arithmetic pipeline up to the output register; uses sdeg_pkg
module sdeg_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  sdeg_pkg::t_coef                      i_coef,
    input  sdeg_pkg::t_qent                      i_head,
    input  logic                                 i_head_valid,
    output logic                                 o_pop,
    input  logic                                 i_stall,
    output logic                                 o_valid,
    output logic signed [sdeg_pkg::GRAD_W-1:0]   o_gradient_value,
    output logic [sdeg_pkg::IDX_W-1:0]           o_frame_index,
    output logic                                 o_row_last
);

    localparam int TAPS     = sdeg_pkg::TAPS;
    localparam int SAMPLE_W = sdeg_pkg::SAMPLE_W;
    localparam int PROD_W   = sdeg_pkg::PROD_W;
    localparam int WEIGHT_W = sdeg_pkg::WEIGHT_W;
    localparam int SPLIT_W  = sdeg_pkg::SPLIT_W;
    localparam int WHI_W    = sdeg_pkg::WHI_W;
    localparam int PLO_W    = sdeg_pkg::PLO_W;
    localparam int PHI_W    = sdeg_pkg::PHI_W;
    localparam int ACC_W    = sdeg_pkg::ACC_W;
    localparam int GRAD_W   = sdeg_pkg::GRAD_W;
    localparam int IDX_W    = sdeg_pkg::IDX_W;
    localparam int RSH      = sdeg_pkg::ROUND_SHIFT;
    localparam int QW       = ACC_W - RSH;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (RSH - 1);

    // coefficient products, refreshed every cycle
    logic signed [PROD_W-1:0] r_p_aa, r_p_bb, r_p_cc, r_p_ab, r_p_bc, r_p_ac;

    logic [1:0] r_sub;

    logic               r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7;
    sdeg_pkg::t_job     r_job1;
    logic signed [WEIGHT_W-1:0] r_w   [TAPS];
    logic [SAMPLE_W-1:0]        r_s2  [TAPS];
    logic signed [PLO_W-1:0]    r_plo [TAPS];
    logic signed [PHI_W-1:0]    r_phi [TAPS];
    logic signed [ACC_W-1:0]    r_tap [TAPS];
    logic signed [ACC_W-1:0]    r_t01, r_t23, r_t4, r_sum;
    sdeg_pkg::t_tag             r_tag2, r_tag3, r_tag4, r_tag5, r_tag6, r_tag7;
    logic signed [GRAD_W-1:0]   r_grad;

    logic           pipe_en;
    logic           issue;
    sdeg_pkg::t_job job;
    logic signed [WEIGHT_W-1:0] n_w [TAPS];
    logic signed [ACC_W-1:0]    rounded;
    logic signed [QW-1:0]       q;
    logic [QW-GRAD_W:0]         q_top;
    logic signed [GRAD_W-1:0]   n_grad;

    // whole pipe moves unless the output register is held
    assign pipe_en = !r_v7 || !i_stall;
    assign issue   = pipe_en && i_head_valid;
    assign o_pop   = issue && (!i_head.flush || r_sub == 2'd2);

    // job for frame n-2+sub: tap k reads sample k+sub of the entry
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            if (k + int'(r_sub) < TAPS) begin
                job.taps[k] = i_head.samples[k + int'(r_sub)];
            end else begin
                job.taps[k] = '0;
            end
        end
        job.has_c           = r_sub == 2'd0;
        job.has_b           = i_head.flush ? (r_sub != 2'd2) : i_head.ge3;
        job.has_a           = (r_sub == 2'd0) ? i_head.ge4 : 1'b1;
        job.tag.frame_index = i_head.idx - IDX_W'(2) + IDX_W'(r_sub);
        job.tag.row_last    = i_head.flush && (r_sub == 2'd2);
    end

    // tap weights from the reduced or full stencil
    always_comb begin
        n_w[4] = r_job1.has_c ? WEIGHT_W'(r_p_ac) : '0;
        n_w[3] = (r_job1.has_c ? WEIGHT_W'(r_p_bc) : '0)
               + (r_job1.has_b ? WEIGHT_W'(r_p_ab) : '0);
        n_w[2] = (r_job1.has_c ? WEIGHT_W'(r_p_cc) : '0)
               + (r_job1.has_b ? WEIGHT_W'(r_p_bb) : '0)
               + (r_job1.has_a ? WEIGHT_W'(r_p_aa) : '0);
        n_w[1] = (r_job1.has_b ? WEIGHT_W'(r_p_bc) : '0)
               + (r_job1.has_a ? WEIGHT_W'(r_p_ab) : '0);
        n_w[0] = r_job1.has_a ? WEIGHT_W'(r_p_ac) : '0;
    end

    // round half up to q32.16 and saturate to 48 bits
    always_comb begin
        rounded = r_sum + $signed(ROUND_HALF);
        q       = QW'(rounded >>> RSH);
        q_top   = q[QW-1:GRAD_W-1];
        if (q_top == '0 || q_top == '1) begin
            n_grad = q[GRAD_W-1:0];
        end else if (q[QW-1]) begin
            n_grad = {1'b1, {(GRAD_W-1){1'b0}}};
        end else begin
            n_grad = {1'b0, {(GRAD_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_aa <= i_coef.a * i_coef.a;
        r_p_bb <= i_coef.b * i_coef.b;
        r_p_cc <= i_coef.c * i_coef.c;
        r_p_ab <= i_coef.a * i_coef.b;
        r_p_bc <= i_coef.b * i_coef.c;
        r_p_ac <= i_coef.a * i_coef.c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_v4  <= 1'b0;
            r_v5  <= 1'b0;
            r_v6  <= 1'b0;
            r_v7  <= 1'b0;
        end else if (pipe_en) begin
            if (issue) begin
                r_sub <= o_pop ? 2'd0 : r_sub + 2'd1;
            end
            r_v1 <= issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pipe_en) begin
            r_job1 <= job;
            r_tag2 <= r_job1.tag;
            r_tag3 <= r_tag2;
            r_tag4 <= r_tag3;
            r_tag5 <= r_tag4;
            r_tag6 <= r_tag5;
            r_tag7 <= r_tag6;
            for (int k = 0; k < TAPS; k++) begin
                r_w[k]   <= n_w[k];
                r_s2[k]  <= r_job1.taps[k];
                // weight split into unsigned low and signed high part
                r_plo[k] <= $signed({1'b0, r_w[k][SPLIT_W-1:0]}) * $signed(r_s2[k]);
                r_phi[k] <= $signed(r_w[k][WEIGHT_W-1:SPLIT_W]) * $signed(r_s2[k]);
                r_tap[k] <= (ACC_W'(r_phi[k]) <<< SPLIT_W) + ACC_W'(r_plo[k]);
            end
            r_t01  <= r_tap[0] + r_tap[1];
            r_t23  <= r_tap[2] + r_tap[3];
            r_t4   <= r_tap[4];
            r_sum  <= r_t01 + r_t23 + r_t4;
            r_grad <= n_grad;
        end
    end

    assign o_valid          = r_v7;
    assign o_gradient_value = r_grad;
    assign o_frame_index    = r_tag7.frame_index;
    assign o_row_last       = r_tag7.row_last;

endmodule

[hdl/second_difference_energy_gradient_core.sv]
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+---------------------------------------
// sample    | in        | i_valid / o_stall    | i_sample_value
// gradient  | out       | o_valid / i_stall    | o_gradient_value, o_frame_index, o_row_last
// config    | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//
// one sample request is taken per cycle while the four-entry queue has room; a
// sample that closes a row yields three gradients, which the back issues one after
// another, so a row of t frames yields t gradients; the back keeps pace unless stalled.
// a released gradient passes the queue and every register stage of the back before it shows.
// reset is synchronous and active low; coefficients clear to zero, frame count to four.
// an output stall freezes the whole arithmetic pipe; the front keeps filling the queue.
//
// top level of the second-difference energy gradient core; holds the
// configuration registers and joins sdeg_front, sdeg_queue and sdeg_back (sdeg_pkg)
module second_difference_energy_gradient_core #(
    parameter int MAX_FRAMES  = sdeg_pkg::MAX_FRAMES_DEF,
    parameter int QUEUE_DEPTH = sdeg_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration write port
    input  logic                                 i_cfg_we,
    input  logic [sdeg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sdeg_pkg::COEF_W-1:0]          i_cfg_data,
    // sample requests
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [sdeg_pkg::SAMPLE_W-1:0] i_sample_value,
    // gradient requests
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [sdeg_pkg::GRAD_W-1:0]   o_gradient_value,
    output logic [sdeg_pkg::IDX_W-1:0]           o_frame_index,
    output logic                                 o_row_last
);

    // configuration registers
    sdeg_pkg::t_coef                 r_coef;
    logic [sdeg_pkg::FCOUNT_W-1:0]   r_frame_count;

    // front to queue
    logic            push;
    sdeg_pkg::t_qent entry;
    logic            full;

    // queue to back
    sdeg_pkg::t_qent head;
    logic            head_valid;
    logic            pop;

    // writes land at once; the block trusts software to write only while the pipe is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.a      <= '0;
            r_coef.b      <= '0;
            r_coef.c      <= '0;
            r_frame_count <= sdeg_pkg::FCOUNT_W'(sdeg_pkg::FCOUNT_MIN);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sdeg_pkg::CFG_COEF_A:      r_coef.a      <= i_cfg_data;
                sdeg_pkg::CFG_COEF_B:      r_coef.b      <= i_cfg_data;
                sdeg_pkg::CFG_COEF_C:      r_coef.c      <= i_cfg_data;
                sdeg_pkg::CFG_FRAME_COUNT: r_frame_count <= i_cfg_data[sdeg_pkg::FCOUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // front: sample window, frame counter, row end detection
    sdeg_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_sample_value (i_sample_value),
        .i_frame_count  (r_frame_count),
        .i_full         (full),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_entry        (entry)
    );

    // decoupling queue so the front keeps taking samples during a flush
    sdeg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_entry      (entry),
        .i_pop        (pop),
        .o_head       (head),
        .o_head_valid (head_valid),
        .o_full       (full)
    );

    // back: job expansion, multiply-add pipeline, rounding and saturation
    sdeg_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_coef           (r_coef),
        .i_head           (head),
        .i_head_valid     (head_valid),
        .o_pop            (pop),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_gradient_value (o_gradient_value),
        .o_frame_index    (o_frame_index),
        .o_row_last       (o_row_last)
    );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for second_difference_energy_gradient_core: directed and random
// sample rows, predicted gradients compared field by field; depends on sdeg_pkg and the core
module testbench;
    import sdeg_pkg::*;

    localparam int DRAIN_CYCLES = 24;     // well past the trip through the pipe
    localparam int STALL_LIMIT  = 4000;   // cycles with no request moving on either side
    localparam int LONG_ROW     = 100;

    typedef struct {
        logic signed [GRAD_W-1:0] gradient;
        logic [IDX_W-1:0]         frame;
        logic                     last;
    } t_gradient_exp;

    logic                       i_clk;
    logic                       i_rst_n          = 1'b0;
    logic                       i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index      = '0;
    logic [COEF_W-1:0]          i_cfg_data       = '0;
    logic                       i_valid          = 1'b0;
    logic                       o_stall;
    logic signed [SAMPLE_W-1:0] i_sample_value   = '0;
    logic                       o_valid;
    logic                       i_stall          = 1'b0;
    logic signed [GRAD_W-1:0]   o_gradient_value;
    logic [IDX_W-1:0]           o_frame_index;
    logic                       o_row_last;

    // shadow of the configuration and of the row state
    logic signed [COEF_W-1:0]   m_coef_a;
    logic signed [COEF_W-1:0]   m_coef_b;
    logic signed [COEF_W-1:0]   m_coef_c;
    logic [FCOUNT_W-1:0]        m_frames;
    logic signed [SAMPLE_W-1:0] sample_hist [0:3];   // [0] newest .. [3] oldest
    int                         next_frame;
    logic signed [SAMPLE_W-1:0] tap_buf [0:4];       // [0] z[n-4] .. [4] z[n]

    t_gradient_exp expected_gradients [$];
    int            error_count;
    int            idle_cycles;
    int            send_idle_pct;
    int            recv_stall_pct;

    second_difference_energy_gradient_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_sample_value   (i_sample_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_gradient_value (o_gradient_value),
        .o_frame_index    (o_frame_index),
        .o_row_last       (o_row_last)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // exact product coef*coef*sample, q48.48 in a 128 bit word
    function automatic logic signed [127:0] wide_term(input logic signed [COEF_W-1:0] p,
                                                      input logic signed [COEF_W-1:0] q,
                                                      input logic signed [SAMPLE_W-1:0] z);
        logic signed [127:0] wp;
        logic signed [127:0] wq;
        logic signed [127:0] wz;
        wp = p;
        wq = q;
        wz = z;
        return wp * wq * wz;
    endfunction

    // gradient at tap_buf[e]; each flag keeps one residual term that touches the frame
    function automatic logic signed [GRAD_W-1:0] stencil_gradient(input int e,
                                                                  input bit use_c,
                                                                  input bit use_b,
                                                                  input bit use_a);
        logic signed [127:0] acc;
        logic signed [127:0] rounded;
        acc = '0;
        if (use_c) begin
            acc = acc + wide_term(m_coef_c, m_coef_a, tap_buf[e+2])
                      + wide_term(m_coef_c, m_coef_b, tap_buf[e+1])
                      + wide_term(m_coef_c, m_coef_c, tap_buf[e]);
        end
        if (use_b) begin
            acc = acc + wide_term(m_coef_b, m_coef_a, tap_buf[e+1])
                      + wide_term(m_coef_b, m_coef_b, tap_buf[e])
                      + wide_term(m_coef_b, m_coef_c, tap_buf[e-1]);
        end
        if (use_a) begin
            acc = acc + wide_term(m_coef_a, m_coef_a, tap_buf[e])
                      + wide_term(m_coef_a, m_coef_b, tap_buf[e-1])
                      + wide_term(m_coef_a, m_coef_c, tap_buf[e-2]);
        end
        // round half up to q32.16, then clip to 48 bits
        rounded = (acc + (128'sd1 <<< 31)) >>> ROUND_SHIFT;
        if (rounded[127:GRAD_W-1] != '0 && rounded[127:GRAD_W-1] != '1) begin
            return rounded[127] ? {1'b1, {(GRAD_W-1){1'b0}}} : {1'b0, {(GRAD_W-1){1'b1}}};
        end
        return rounded[GRAD_W-1:0];
    endfunction

    task automatic queue_gradient(input logic signed [GRAD_W-1:0] g, input int frame,
                                  input bit last);
        t_gradient_exp rec;
        rec.gradient = g;
        rec.frame    = frame[IDX_W-1:0];
        rec.last     = last;
        expected_gradients.push_back(rec);
    endtask

    // works out the gradients one accepted sample request releases
    task automatic predict_gradients(input logic signed [SAMPLE_W-1:0] sample);
        int n;
        int frames;
        n = next_frame;
        frames = m_frames;
        if (frames < FCOUNT_MIN) frames = FCOUNT_MIN;
        if (frames > MAX_FRAMES_DEF) frames = MAX_FRAMES_DEF;
        tap_buf[0] = sample_hist[3];
        tap_buf[1] = sample_hist[2];
        tap_buf[2] = sample_hist[1];
        tap_buf[3] = sample_hist[0];
        tap_buf[4] = sample;
        if (n + 1 >= frames) begin
            // row closes: flush the last three frames, then start clean
            queue_gradient(stencil_gradient(2, 1, 1, n - 2 >= 2), n - 2, 1'b0);
            queue_gradient(stencil_gradient(3, 0, 1, 1), n - 1, 1'b0);
            queue_gradient(stencil_gradient(4, 0, 0, 1), n, 1'b1);
            for (int i = 0; i < 4; i++) sample_hist[i] = '0;
            next_frame = 0;
        end else begin
            if (n >= 2) queue_gradient(stencil_gradient(2, 1, n - 2 >= 1, n - 2 >= 2), n - 2, 1'b0);
            sample_hist[3] = sample_hist[2];
            sample_hist[2] = sample_hist[1];
            sample_hist[1] = sample_hist[0];
            sample_hist[0] = sample;
            next_frame = n + 1;
        end
    endtask

    task automatic report_mismatch(input string what, input int frame, input longint got,
                                   input longint want);
        if (error_count < 100) begin
            $display("mismatch at frame %0d: %s got %0d want %0d", frame, what, got, want);
        end
        error_count++;
    endtask

    // one sample request; valid stays high on return so the next one can follow at once
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid        <= 1'b1;
        i_sample_value <= value;
        do @(posedge i_clk); while (o_stall);
        predict_gradients(value);
    endtask

    // sender holds off until every gradient is back and the pipe has emptied
    task automatic wait_for_idle();
        i_valid <= 1'b0;
        while (expected_gradients.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [COEF_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_COEF_A:      m_coef_a = data;
            CFG_COEF_B:      m_coef_b = data;
            CFG_COEF_C:      m_coef_c = data;
            CFG_FRAME_COUNT: m_frames = data[FCOUNT_W-1:0];
            default:         ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(0, 32'h8_0000)) - 32'h4_0000;   // within +-4.0
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3, 4, 5: return $urandom;
            default: return 32'($urandom_range(0, 32'h200_0000)) - 32'h100_0000;  // +-256.0
        endcase
    endfunction

    task automatic write_random_coefs();
        write_reg(CFG_COEF_A, rand_coef());
        write_reg(CFG_COEF_B, rand_coef());
        write_reg(CFG_COEF_C, rand_coef());
    endtask

    // receiver side: random stalls at the rate of the current phase
    always @(posedge i_clk) begin
        i_stall <= (recv_stall_pct > 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // compare every gradient request with the oldest prediction
    always @(posedge i_clk) begin
        t_gradient_exp want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_gradients.size() == 0) begin
                report_mismatch("gradient with none pending", o_frame_index, o_gradient_value, 0);
            end else begin
                want = expected_gradients.pop_front();
                if (o_gradient_value !== want.gradient)
                    report_mismatch("gradient_value", want.frame, o_gradient_value, want.gradient);
                if (o_frame_index !== want.frame)
                    report_mismatch("frame_index", want.frame, o_frame_index, want.frame);
                if (o_row_last !== want.last)
                    report_mismatch("row_last", want.frame, o_row_last, want.last);
            end
        end
    end

    // watchdog: nothing moving on either channel for too long ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == STALL_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // registers at their reset values: all-zero coefficients, four frames per row
    task automatic test_reset_state();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_sample(32'h1234_5678);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        wait_for_idle();
    endtask

    // field extremes, saturation both ways, rounding at the half and short frame counts
    task automatic test_directed_extremes();
        // a = 1.0, b = -2.0, c = 1.0: plain second difference
        write_reg(CFG_COEF_A, 32'h0001_0000);
        write_reg(CFG_COEF_B, 32'hFFFE_0000);
        write_reg(CFG_COEF_C, 32'h0001_0000);
        write_reg(CFG_FRAME_COUNT, 32'd4);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        wait_for_idle();

        // largest coefficients drive the sums far past 48 bits
        write_reg(CFG_COEF_A, 32'h7FFF_FFFF);
        write_reg(CFG_COEF_B, 32'h8000_0000);
        write_reg(CFG_COEF_C, 32'h7FFF_FFFF);
        write_reg(CFG_FRAME_COUNT, 32'd5);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        wait_for_idle();

        // frame count of zero behaves as four
        write_reg(CFG_COEF_A, 32'h8000_0000);
        write_reg(CFG_COEF_B, 32'h7FFF_FFFF);
        write_reg(CFG_COEF_C, 32'h8000_0000);
        write_reg(CFG_FRAME_COUNT, 32'd0);
        send_sample(32'h8000_0000);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'h0000_0001);
        wait_for_idle();

        // tiny coefficients leave sums sitting exactly on the rounding half
        write_reg(CFG_COEF_A, 32'd1);
        write_reg(CFG_COEF_B, 32'd0);
        write_reg(CFG_COEF_C, 32'd1);
        write_reg(CFG_FRAME_COUNT, 32'd3);
        send_sample(32'h8000_0000);
        send_sample(32'h7FFF_FFFF);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h8000_0001);
        wait_for_idle();
    endtask

    // coefficients changed part-way through a row, then the frame count lowered below
    // the current index so the next sample closes the row
    task automatic test_mid_row_writes();
        write_random_coefs();
        write_reg(CFG_FRAME_COUNT, 32'h0000_1FFF);   // above the maximum, acts as the maximum
        repeat (6) send_sample(rand_sample());
        wait_for_idle();
        write_random_coefs();
        repeat (3) send_sample(rand_sample());
        wait_for_idle();
        write_reg(CFG_FRAME_COUNT, 32'd4);
        send_sample(rand_sample());
        wait_for_idle();
    endtask

    // one long row streamed back to back with the full stencil in steady flow
    task automatic test_long_row();
        write_reg(CFG_COEF_A, 32'h0000_8000);
        write_reg(CFG_COEF_B, 32'hFFFF_4000);
        write_reg(CFG_COEF_C, 32'h0000_4000);
        write_reg(CFG_FRAME_COUNT, 32'(LONG_ROW));
        repeat (LONG_ROW) send_sample(rand_sample());
        wait_for_idle();
    endtask

    // mostly whole rows with random content, now and then one cut short by a lower count
    task automatic test_random_rows(input int send_pct, input int recv_pct, input int quota);
        int sent;
        int frames;
        int row_len;
        int cut;
        bit first;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        sent  = 0;
        first = 1'b1;
        while (sent < quota) begin
            if (first || $urandom_range(2) == 0) begin
                wait_for_idle();
                write_random_coefs();
                case ($urandom_range(19))
                    0:       frames = $urandom_range(0, 3);
                    1, 2:    frames = $urandom_range(13, 40);
                    default: frames = $urandom_range(4, 12);
                endcase
                // bits above the count field are ignored by the block
                write_reg(CFG_FRAME_COUNT,
                          {($urandom_range(3) == 0) ? 19'($urandom) : 19'd0, 13'(frames)});
                first = 1'b0;
            end
            row_len = (m_frames < FCOUNT_MIN) ? FCOUNT_MIN : m_frames;
            if ($urandom_range(5) == 0) begin
                cut = $urandom_range(1, row_len - 1);
                repeat (cut) send_sample(rand_sample());
                wait_for_idle();
                write_reg(CFG_FRAME_COUNT, 32'($urandom_range(0, cut + 1)));
                send_sample(rand_sample());
                sent += cut + 1;
            end else begin
                repeat (row_len) send_sample(rand_sample());
                sent += row_len;
            end
        end
        wait_for_idle();
    endtask

    initial begin
        m_coef_a    = '0;
        m_coef_b    = '0;
        m_coef_c    = '0;
        m_frames    = FCOUNT_W'(FCOUNT_MIN);
        next_frame  = 0;
        error_count = 0;
        idle_cycles = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 4; i++) sample_hist[i] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_extremes();
        test_mid_row_writes();
        test_long_row();
        test_random_rows(0, 0, 57);
        test_random_rows(85, 0, 57);
        test_random_rows(0, 85, 57);
        test_random_rows(29, 29, 57);

        wait_for_idle();
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[files.f]
hdl/sdeg_pkg.sv
hdl/sdeg_front.sv
hdl/sdeg_queue.sv
hdl/sdeg_back.sv
hdl/second_difference_energy_gradient_core.sv
tb/sv/testbench.sv
